// ===== design/npcm_pkg.sv =====
package npcm_pkg;

    localparam int PALETTE_DEPTH = 1024;
    localparam int IDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PALETTE_DEPTH + 1);
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = 18;
    localparam int OIDX_W  = 10;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int TILE_W  = 12;
    localparam int PIX_W   = 24;

    localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(255 * 255 * 3);
    localparam logic [TILE_W-1:0] TILE_MAX   = '1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILES_PER_ROW = 1'b0,
        CFG_TILE_SIDE     = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [OIDX_W-1:0] best_index;
        logic [DIST_W-1:0] best_distance;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
    } t_out_item;

    // One palette entry presented to the distance unit
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] query;
        logic [COLOR_W-1:0] entry;
    } t_dist_req;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] sq_dist;
    } t_dist_res;

endpackage

// ===== design/npcm_ram.sv =====
module npcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/npcm_dist.sv =====
module npcm_dist (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  npcm_pkg::t_dist_req   i_req,
    output npcm_pkg::t_dist_res   o_res,
    output logic                  o_busy
);
    import npcm_pkg::*;

    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_index;
    logic [SQ_W-1:0]   r_sq [3];
    logic [SQ_W-1:0]   n_sq [3];
    t_dist_res         r_res;

    // Absolute difference and square per channel
    always_comb begin
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] d;
        for (int c = 0; c < 3; c++) begin
            a = i_req.query[c*CHAN_W +: CHAN_W];
            b = i_req.entry[c*CHAN_W +: CHAN_W];
            d = (a > b) ? (a - b) : (b - a);
            n_sq[c] = SQ_W'(d) * SQ_W'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_req.valid;
            r_res.valid <= r_s1_valid;
        end
        r_s1_index <= i_req.index;
        for (int c = 0; c < 3; c++) begin
            r_sq[c] <= n_sq[c];
        end
        r_res.index   <= r_s1_index;
        r_res.sq_dist <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    end

    assign o_res  = r_res;
    assign o_busy = r_s1_valid | r_res.valid;

endmodule

// ===== design/nearest_palette_color_match_top.sv =====
// Nearest palette color match. Load transactions (req_type 0) append one
// blue/green/red color to a palette of up to PALETTE_DEPTH entries held in a
// single RAM; loads into a full palette are dropped. Clear transactions
// (req_type 2) empty the palette and zero the tile row and column counters.
// Load and clear produce no result. A query transaction (req_type 1) scans
// every loaded entry through one RAM read port and one pipelined
// squared-distance unit, one entry per cycle, and keeps the first entry whose
// distance is smallest and strictly below 195075. The scan rate is bounded by
// the single RAM read port that feeds the distance unit, and
// the input is stalled while
// a query is in flight. The result goes to an output
// register, so a finished result waiting on a stalled output does not hold
// off the next transaction once it is stored. Each query then advances the
// tile column counter, wrapping into the next row at tiles_per_row columns.
// The palette RAM has no reset and needs no clearing pass: only entries below
// the fill count are ever read. Configuration (index 0 tiles_per_row, index 1
// tile_side) may be written only while no query is in flight.
module nearest_palette_color_match_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  npcm_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output npcm_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [npcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [npcm_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import npcm_pkg::*;

    t_state r_state;
    t_state n_state;

    // Configuration
    logic [CFG_W-1:0]   r_tiles_per_row;
    logic [CFG_W-1:0]   r_tile_side;

    // Palette fill level and tile raster
    logic [CNT_W-1:0]   r_count;
    logic [TILE_W-1:0]  r_col;
    logic [TILE_W-1:0]  r_row;

    // Query context
    logic [COLOR_W-1:0] r_query;
    logic [CNT_W-1:0]   r_scan;
    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_rd_index;
    logic [DIST_W-1:0]  r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_hit;
    logic [PIX_W-1:0]   r_px;
    logic [PIX_W-1:0]   r_py;

    // Output register
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_accept;
    logic               issue;
    logic               finish;
    logic               pipe_busy;
    logic               last_issue;
    logic               ram_we;
    logic [COLOR_W-1:0] ram_rdata;
    t_dist_req          dreq;
    t_dist_res          dres;
    logic [TILE_W:0]    col_next;

    assign in_accept  = i_in_valid & ~o_in_stall;
    assign last_issue = (CNT_W'(r_scan + 1'b1) == r_count);
    assign ram_we     = in_accept && (i_in.req_type == REQ_LOAD) &&
                        (r_count < CNT_W'(PALETTE_DEPTH));

    npcm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_in.red, i_in.green, i_in.blue}),
        .i_re    (issue),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign dreq.valid = r_rd_valid;
    assign dreq.index = r_rd_index;
    assign dreq.query = r_query;
    assign dreq.entry = ram_rdata;

    npcm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_res   (dres),
        .o_busy  (pipe_busy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in.req_type == REQ_QUERY)) begin
                    n_state = (r_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        finish     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCAN:  issue = 1'b1;
            S_DRAIN: ;
            S_DONE:  finish = ~r_out_valid | ~i_out_stall;
            default: ;
        endcase
    end

    assign col_next = {1'b0, r_col} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_tiles_per_row <= CFG_W'(1);
            r_tile_side     <= CFG_W'(1);
            r_count         <= '0;
            r_col           <= '0;
            r_row           <= '0;
            r_rd_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= issue;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TILES_PER_ROW: r_tiles_per_row <= i_cfg_wdata;
                    CFG_TILE_SIDE:     r_tile_side     <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (in_accept) begin
                case (i_in.req_type)
                    REQ_LOAD: begin
                        if (ram_we) begin
                            r_count <= CNT_W'(r_count + 1'b1);
                        end
                    end
                    REQ_CLEAR: begin
                        r_count <= '0;
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    default: ;
                endcase
            end

            // Advance the raster once the result is stored
            if (finish) begin
                if ((col_next >= r_tiles_per_row) || (r_col == TILE_MAX)) begin
                    r_col <= '0;
                    r_row <= TILE_W'(r_row + 1'b1);
                end else begin
                    r_col <= col_next[TILE_W-1:0];
                end
            end

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query datapath
    always_ff @(posedge i_clk) begin
        r_px <= PIX_W'(r_col) * PIX_W'(r_tile_side);
        r_py <= PIX_W'(r_row) * PIX_W'(r_tile_side);
        r_rd_index <= r_scan[IDX_W-1:0];

        if (in_accept && (i_in.req_type == REQ_QUERY)) begin
            r_query    <= {i_in.red, i_in.green, i_in.blue};
            r_scan     <= '0;
            r_best     <= DIST_LIMIT;
            r_best_idx <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (issue) begin
                r_scan <= CNT_W'(r_scan + 1'b1);
            end
            // Strict compare keeps the first minimum
            if (dres.valid && (dres.sq_dist < r_best)) begin
                r_best     <= dres.sq_dist;
                r_best_idx <= dres.index;
                r_hit      <= 1'b1;
            end
        end

        if (finish) begin
            r_out.found         <= r_hit;
            r_out.best_index    <= OIDX_W'(r_best_idx);
            r_out.best_distance <= r_best;
            r_out.pixel_x       <= r_px;
            r_out.pixel_y       <= r_py;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    a_found_matches_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.found == (o_out.best_distance < DIST_LIMIT)))
        else $error("found flag disagrees with distance");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.best_index == '0))
        else $error("miss reported with nonzero index");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PALETTE_DEPTH))
        else $error("palette count beyond depth");

    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dres.valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("distance result outside a scan");

endmodule
